// ----- design/ntpms_pkg.sv -----
package ntpms_pkg;

  typedef enum logic [1:0] {
    OP_ADD_MS  = 2'd0,
    OP_SUB_MS  = 2'd1,
    OP_DIFF_MS = 2'd2,
    OP_COMPARE = 2'd3
  } op_t;

  localparam logic [1:0] ORD_EQ = 2'd0;
  localparam logic [1:0] ORD_LT = 2'd1;
  localparam logic [1:0] ORD_GT = 2'd2;

  // 1 ms approximated in 2^-32 s steps
  localparam logic [22:0] STEPS_PER_MS = 23'd4294967;
  localparam logic [9:0]  MS_PER_SEC   = 10'd1000;

  // floor(x / 1000) == ((x >> 3) * DIV_MS_MULT) >> DIV_MS_SHIFT for 32-bit x
  localparam logic [29:0] DIV_MS_MULT  = 30'd549755814;
  localparam int          DIV_MS_SHIFT = 36;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] a_seconds;
    logic [31:0] a_fraction;
    logic [31:0] b_seconds;
    logic [31:0] b_fraction;
    logic [31:0] delay_ms;
  } in_item_t;

  typedef struct packed {
    logic [31:0]        result_seconds;
    logic [31:0]        result_fraction;
    logic signed [31:0] diff_millis;
    logic [1:0]         order;
  } out_item_t;

endpackage

// ----- design/ntp_timestamp_ms_alu_unit.sv -----
// Throughput: one item per cycle; each stage holds only while the stage after it is full
// and stalled, so bubbles are squeezed out behind a stalled output.
// Reset (rst_n low, synchronous) clears all stage valid bits; payload registers are not reset.
module ntp_timestamp_ms_alu_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ntpms_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ntpms_pkg::out_item_t out_data
);
  import ntpms_pkg::*;

  // stage valids and per-stage advance
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic adv1, adv2, adv3, adv4, adv5, adv6;

  assign adv6 = !v6_r || out_ready;
  assign adv5 = !v5_r || adv6;
  assign adv4 = !v4_r || adv5;
  assign adv3 = !v3_r || adv4;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;
  assign in_ready = adv1;

  // ---------------- stage 1: reciprocal product for delay / 1000
  logic [1:0]  op1_r;
  logic [31:0] as1_r, af1_r, bs1_r, bf1_r, dm1_r;
  logic [58:0] prod1_r, prod1_nxt;

  assign prod1_nxt = 59'(in_data.delay_ms[31:3]) * 59'(DIV_MS_MULT);

  always_ff @(posedge clk) begin
    if (adv1) begin
      op1_r   <= in_data.operation;
      as1_r   <= in_data.a_seconds;
      af1_r   <= in_data.a_fraction;
      bs1_r   <= in_data.b_seconds;
      bf1_r   <= in_data.b_fraction;
      dm1_r   <= in_data.delay_ms;
      prod1_r <= prod1_nxt;
    end
  end

  // ---------------- stage 2: quotient, remainder, 64-bit differences
  logic [1:0]  op2_r;
  logic [31:0] as2_r, af2_r;
  logic [22:0] q2_r, q2_nxt;
  logic [9:0]  r2_r, r2_nxt;
  logic [32:0] qk2;
  logic [31:0] rem2;
  logic [64:0] dab2;
  logic [63:0] dab2_r, dba2_r, dba2_nxt;
  logic        lt2_r, eq2_r;

  assign q2_nxt   = prod1_r[58:DIV_MS_SHIFT];
  assign qk2      = 33'(q2_nxt) * 33'(MS_PER_SEC);
  assign rem2     = dm1_r - qk2[31:0];
  assign r2_nxt   = rem2[9:0];
  assign dab2     = {1'b0, as1_r, af1_r} - {1'b0, bs1_r, bf1_r};
  assign dba2_nxt = {bs1_r, bf1_r} - {as1_r, af1_r};

  always_ff @(posedge clk) begin
    if (adv2) begin
      op2_r  <= op1_r;
      as2_r  <= as1_r;
      af2_r  <= af1_r;
      q2_r   <= q2_nxt;
      r2_r   <= r2_nxt;
      dab2_r <= dab2[63:0];
      dba2_r <= dba2_nxt;
      lt2_r  <= dab2[64];
      eq2_r  <= (dab2[63:0] == 64'd0);
    end
  end

  // ---------------- stage 3: fraction steps, order, magnitude select
  logic [1:0]  op3_r, ord3_r, ord3_nxt;
  logic [31:0] as3_r, af3_r;
  logic [22:0] q3_r;
  logic [32:0] steps3;
  logic [31:0] steps3_r;
  logic [63:0] mag3_r;
  logic        neg3_r;

  assign steps3 = 33'(r2_r) * 33'(STEPS_PER_MS);

  always_comb begin
    if (eq2_r)      ord3_nxt = ORD_EQ;
    else if (lt2_r) ord3_nxt = ORD_LT;
    else            ord3_nxt = ORD_GT;
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      op3_r    <= op2_r;
      as3_r    <= as2_r;
      af3_r    <= af2_r;
      q3_r     <= q2_r;
      steps3_r <= steps3[31:0];
      ord3_r   <= ord3_nxt;
      mag3_r   <= lt2_r ? dba2_r : dab2_r;
      neg3_r   <= lt2_r;
    end
  end

  // ---------------- stage 4: add/sub result, ms products for the difference
  logic [1:0]  op4_r, ord4_r;
  logic [31:0] rs4_r, rf4_r, rs4_nxt, rf4_nxt;
  logic [31:0] secms4_r, frac4_r;
  logic [41:0] fk4;
  logic [9:0]  q04_r;
  logic        neg4_r;
  logic [63:0] sum4, dif4;
  logic [31:0] q4_ext;

  assign q4_ext = 32'(q3_r);
  assign sum4   = {as3_r, af3_r} + {q4_ext, steps3_r};
  assign dif4   = {as3_r, af3_r} - {q4_ext, steps3_r};
  assign fk4    = 42'(mag3_r[31:0]) * 42'(MS_PER_SEC);

  always_comb begin
    rs4_nxt = sum4[63:32];
    rf4_nxt = sum4[31:0];
    if (op3_r == OP_SUB_MS) begin
      if (as3_r > q4_ext) begin
        rs4_nxt = dif4[63:32];
        rf4_nxt = dif4[31:0];
      end else begin
        // clamp at zero seconds
        rs4_nxt = 32'd0;
        rf4_nxt = (steps3_r >= af3_r) ? 32'd0 : (af3_r - steps3_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      op4_r    <= op3_r;
      ord4_r   <= ord3_r;
      rs4_r    <= rs4_nxt;
      rf4_r    <= rf4_nxt;
      secms4_r <= 32'(mag3_r[63:32] * 32'(MS_PER_SEC));
      frac4_r  <= mag3_r[31:0];
      q04_r    <= fk4[41:32];
      neg4_r   <= neg3_r;
    end
  end

  // ---------------- stage 5: quotient correction (estimate is low by at most one)
  logic [1:0]  op5_r, ord5_r;
  logic [31:0] rs5_r, rf5_r, sum5_r;
  logic [32:0] chk5;
  logic        corr5_r, neg5_r;

  assign chk5 = 33'(q04_r + 10'd1) * 33'(STEPS_PER_MS);

  always_ff @(posedge clk) begin
    if (adv5) begin
      op5_r   <= op4_r;
      ord5_r  <= ord4_r;
      rs5_r   <= rs4_r;
      rf5_r   <= rf4_r;
      sum5_r  <= secms4_r + 32'(q04_r);
      corr5_r <= (chk5 <= 33'(frac4_r));
      neg5_r  <= neg4_r;
    end
  end

  // ---------------- stage 6: sign, field gating, output register
  logic [31:0] mag6;
  out_item_t   out6_r, out6_nxt;

  assign mag6 = sum5_r + 32'(corr5_r);

  always_comb begin
    out6_nxt = '0;
    unique case (op5_r) inside
      OP_ADD_MS, OP_SUB_MS: begin
        out6_nxt.result_seconds  = rs5_r;
        out6_nxt.result_fraction = rf5_r;
      end
      OP_DIFF_MS: out6_nxt.diff_millis = neg5_r ? (32'd0 - mag6) : mag6;
      default:    out6_nxt.order = ord5_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv6) begin
      out6_r <= out6_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
      if (adv5) v5_r <= v4_r;
      if (adv6) v6_r <= v5_r;
    end
  end

  assign out_valid = v6_r;
  assign out_data  = out6_r;

endmodule

// ----- tb/sv/ntp_timestamp_ms_alu_unit_test.sv -----
module ntp_timestamp_ms_alu_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ntpms_pkg::*;

  localparam logic [31:0] MS_STEP      = 32'd4294967;
  localparam logic [31:0] MS_IN_SEC    = 32'd1000;
  localparam logic [31:0] WORD_MAX     = 32'hFFFF_FFFF;
  localparam int          RANDOM_ITEMS = 1100;
  localparam int          QUIET_TAIL   = 120;
  localparam int          DRAIN_CYCLES = 16;
  localparam int          CYCLE_LIMIT  = 200000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  int        mismatch_count = 0;
  int        cycle_count = 0;
  int        in_gap = 0;
  int        out_gap = 0;
  logic      quiet_tail = 1'b0;

  ntp_timestamp_ms_alu_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #2 clk = ~clk;

  function automatic logic [1:0] ts_order(logic [31:0] as, logic [31:0] af,
                                          logic [31:0] bs, logic [31:0] bf);
    if (as != bs) return (as < bs) ? ORD_LT : ORD_GT;
    if (af != bf) return (af < bf) ? ORD_LT : ORD_GT;
    return ORD_EQ;
  endfunction

  // later (hs,hf) minus earlier (ls,lf), in ms, fraction wraps mod 2^32
  function automatic logic [31:0] elapsed_ms(logic [31:0] hs, logic [31:0] hf,
                                             logic [31:0] ls, logic [31:0] lf);
    logic [31:0] sec;
    logic [31:0] frac;
    sec  = hs - ls;
    frac = hf - lf;
    if (hf < lf) sec = sec - 32'd1;
    return sec * MS_IN_SEC + frac / MS_STEP;
  endfunction

  function automatic out_item_t predict_timestamp(in_item_t it);
    out_item_t   r;
    logic [31:0] whole_s;
    logic [31:0] steps;
    logic [1:0]  ord;
    r       = '0;
    whole_s = it.delay_ms / MS_IN_SEC;
    steps   = (it.delay_ms % MS_IN_SEC) * MS_STEP;
    case (it.operation)
      OP_ADD_MS: begin
        r.result_fraction = it.a_fraction + steps;
        r.result_seconds  = it.a_seconds + whole_s;
        if (r.result_fraction < it.a_fraction) r.result_seconds = r.result_seconds + 32'd1;
      end
      OP_SUB_MS: begin
        if (it.a_seconds > whole_s) begin
          r.result_seconds  = it.a_seconds - whole_s;
          r.result_fraction = it.a_fraction - steps;
          if (steps > it.a_fraction) r.result_seconds = r.result_seconds - 32'd1;
        end else begin
          // saturate: seconds pinned at zero, fraction clipped at zero
          r.result_fraction = (steps >= it.a_fraction) ? 32'd0 : it.a_fraction - steps;
        end
      end
      OP_DIFF_MS: begin
        ord = ts_order(it.a_seconds, it.a_fraction, it.b_seconds, it.b_fraction);
        if (ord == ORD_GT) begin
          r.diff_millis = elapsed_ms(it.a_seconds, it.a_fraction, it.b_seconds, it.b_fraction);
        end else if (ord == ORD_LT) begin
          r.diff_millis = 32'd0 - elapsed_ms(it.b_seconds, it.b_fraction,
                                             it.a_seconds, it.a_fraction);
        end
      end
      default: begin
        r.order = ts_order(it.a_seconds, it.a_fraction, it.b_seconds, it.b_fraction);
      end
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return WORD_MAX;
      2: return $urandom_range(0, 15);
      3: return WORD_MAX - $urandom_range(0, 15);
      4: return 32'd1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_delay();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return WORD_MAX;
      2: return $urandom_range(0, 999);
      3: return $urandom_range(0, 5000) * MS_IN_SEC + 32'd999;
      4: return $urandom_range(0, 100000);
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_item(op_t op, logic [31:0] as, logic [31:0] af,
                            logic [31:0] bs, logic [31:0] bf, logic [31:0] dm);
    in_item_t it;
    it.operation  = op;
    it.a_seconds  = as;
    it.a_fraction = af;
    it.b_seconds  = bs;
    it.b_fraction = bf;
    it.delay_ms   = dm;
    pending_items.push_back(it);
  endtask

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected 'h%h, got 'h%h", name, exp_val, act_val);
      mismatch_count++;
    end
  endtask

  // idling only outside the quiet tail, and never while bits 8:7 of cycle_count are both set
  function automatic logic idle_allowed();
    return !quiet_tail && (cycle_count[8:7] != 2'b11);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else begin
      quiet_tail <= (pending_items.size() <= QUIET_TAIL);
      if (in_valid && in_ready) expected_results.push_back(predict_timestamp(in_data));
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap   <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() == 0) begin
          in_valid <= 1'b0;
        end else if (idle_allowed() && $urandom_range(0, 5) == 0) begin
          in_gap   <= $urandom_range(0, 2);
          in_valid <= 1'b0;
        end else begin
          in_data  <= pending_items.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t exp_item;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_gap   <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result item with no expectation waiting: 'h%h", out_data);
          mismatch_count++;
        end else begin
          exp_item = expected_results.pop_front();
          check_field("result_seconds", exp_item.result_seconds, out_data.result_seconds);
          check_field("result_fraction", exp_item.result_fraction, out_data.result_fraction);
          check_field("diff_millis", exp_item.diff_millis, out_data.diff_millis);
          check_field("order", {30'd0, exp_item.order}, {30'd0, out_data.order});
        end
      end
      if (out_gap > 0) begin
        out_gap   <= out_gap - 1;
        out_ready <= 1'b0;
      end else if (idle_allowed() && $urandom_range(0, 5) == 0) begin
        out_gap   <= $urandom_range(0, 2);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    op_t         op;
    logic [31:0] as, af, bs, bf, dm;

    // add: zero, full carry at the top, fraction carry, seconds wrap
    queue_item(OP_ADD_MS, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    queue_item(OP_ADD_MS, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
    queue_item(OP_ADD_MS, 32'd5, 32'hFFFF_FFF0, 32'd0, 32'd0, 32'd999);
    queue_item(OP_ADD_MS, WORD_MAX, 32'd0, 32'd0, 32'd0, 32'd1000);
    queue_item(OP_ADD_MS, 32'd7, 32'd123, 32'd0, 32'd0, 32'd1);
    // sub: plain, with fraction borrow, seconds equal to whole part, underflow
    queue_item(OP_SUB_MS, 32'd10, 32'd100, 32'd0, 32'd0, 32'd0);
    queue_item(OP_SUB_MS, 32'd5, 32'd0, 32'd0, 32'd0, 32'd1);
    queue_item(OP_SUB_MS, 32'd3, WORD_MAX, 32'd0, 32'd0, 32'd3000);
    queue_item(OP_SUB_MS, 32'd2, MS_STEP * 5, 32'd0, 32'd0, 32'd2005);
    queue_item(OP_SUB_MS, 32'd2, MS_STEP * 5 + 1, 32'd0, 32'd0, 32'd2005);
    queue_item(OP_SUB_MS, 32'd0, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
    queue_item(OP_SUB_MS, WORD_MAX, 32'd0, 32'd0, 32'd0, WORD_MAX);
    // diff: equal, extremes both ways, fraction borrow, 32-bit truncation
    queue_item(OP_DIFF_MS, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, 32'd0);
    queue_item(OP_DIFF_MS, WORD_MAX, WORD_MAX, 32'd0, 32'd0, 32'd0);
    queue_item(OP_DIFF_MS, 32'd0, 32'd0, WORD_MAX, WORD_MAX, 32'd0);
    queue_item(OP_DIFF_MS, 32'd10, 32'd5, 32'd9, 32'hFFFF_FFF0, 32'd0);
    queue_item(OP_DIFF_MS, 32'd100, 32'd0, 32'd100, MS_STEP * 3, 32'd0);
    queue_item(OP_DIFF_MS, 32'h8000_0000, 32'd0, 32'd0, 32'd0, 32'd0);
    // compare: equal, by seconds, by fraction, extremes
    queue_item(OP_COMPARE, 32'd42, 32'd42, 32'd42, 32'd42, 32'd0);
    queue_item(OP_COMPARE, 32'd1, WORD_MAX, 32'd2, 32'd0, 32'd0);
    queue_item(OP_COMPARE, 32'd9, 32'd8, 32'd9, 32'd7, 32'd0);
    queue_item(OP_COMPARE, 32'd9, 32'd7, 32'd9, 32'd8, 32'd0);
    queue_item(OP_COMPARE, 32'd0, 32'd0, WORD_MAX, WORD_MAX, WORD_MAX);
    queue_item(OP_COMPARE, WORD_MAX, WORD_MAX, 32'd0, 32'd0, 32'd0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      op = op_t'($urandom_range(0, 3));
      as = rand_word();
      af = rand_word();
      bs = rand_word();
      bf = rand_word();
      dm = rand_delay();
      case (op)
        OP_SUB_MS: begin
          // land near the saturation boundary and the fraction borrow
          if ($urandom_range(0, 2) == 0) as = dm / MS_IN_SEC + $urandom_range(0, 2) - 1;
          if ($urandom_range(0, 3) == 0)
            af = (dm % MS_IN_SEC) * MS_STEP + $urandom_range(0, 2) - 1;
        end
        OP_DIFF_MS, OP_COMPARE: begin
          if ($urandom_range(0, 1) == 0) begin
            bs = as + $urandom_range(0, 4) - 2;
            if ($urandom_range(0, 1) == 0) bf = af + $urandom_range(0, 8) - 4;
          end
        end
        default: ;
      endcase
      queue_item(op, as, af, bs, bf, dm);
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_results.size() != 0) begin
      $error("%0d expected result items never arrived", expected_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
